// File: hdl/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared widths, register indexes and item types of the line follower drive.
// ----------------------------------------------------------------------------
package lfpd_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int LEVEL_W    = 6;
    localparam int GAIN_W     = 16;
    localparam int SPEED_W    = 7;
    localparam int OUT_W      = 8;
    localparam int ERR_W      = 7;
    localparam int DIFF_W     = 8;
    localparam int SUM_W      = 16;
    localparam int FRAC_W     = 10;
    localparam int PROD_P_W   = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W   = GAIN_W + 1 + SUM_W;
    localparam int PROD_D_W   = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W      = PROD_I_W + 2;
    localparam int PID_W      = ACC_W - FRAC_W;
    localparam int DRV_W      = PID_W + 1;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P     = 8'd0,
        REG_GAIN_I     = 8'd1,
        REG_GAIN_D     = 8'd2,
        REG_BASE_LEFT  = 8'd3,
        REG_BASE_RIGHT = 8'd4,
        REG_PIVOT      = 8'd5,
        REG_LINE_THR   = 8'd6,
        REG_DARK_THR   = 8'd7
    } t_reg_idx;

    localparam logic [GAIN_W-1:0]  RST_GAIN_P = 16'd5120;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I = 16'd20;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D = 16'd1024;
    localparam logic [SPEED_W-1:0] RST_SPEED  = 7'd45;
    localparam logic [LEVEL_W-1:0] RST_LINE   = 6'd30;
    localparam logic [LEVEL_W-1:0] RST_DARK   = 6'd5;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [SPEED_W-1:0] base_left;
        logic [SPEED_W-1:0] base_right;
        logic [SPEED_W-1:0] pivot_speed;
        logic [LEVEL_W-1:0] line_thr;
        logic [LEVEL_W-1:0] dark_thr;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] center;
        logic [SAMPLE_W-1:0] right;
    } t_sample;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
        logic                     pivot;
        logic                     turn_left;
    } t_err_item;

    typedef struct packed {
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
        logic                       pivot;
        logic                       turn_left;
    } t_prod_item;

endpackage

// File: hdl/lfpd_intf.sv
// ----------------------------------------------------------------------------
// lfpd channel interfaces
// Sample, drive and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lfpd_sample_if;
    logic                          valid;
    logic                          ready;
    logic [lfpd_pkg::SAMPLE_W-1:0] left_sample;
    logic [lfpd_pkg::SAMPLE_W-1:0] center_sample;
    logic [lfpd_pkg::SAMPLE_W-1:0] right_sample;

    modport source (output valid, left_sample, center_sample, right_sample, input ready);
    modport sink   (input valid, left_sample, center_sample, right_sample, output ready);
endinterface

interface lfpd_drive_if;
    logic                              valid;
    logic                              ready;
    logic signed [lfpd_pkg::OUT_W-1:0] left_speed;
    logic signed [lfpd_pkg::OUT_W-1:0] right_speed;
    logic                              pivoting;

    modport source (output valid, left_speed, right_speed, pivoting, input ready);
    modport sink   (input valid, left_speed, right_speed, pivoting, output ready);
endinterface

interface lfpd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lfpd_pkg::CFG_IDX_W-1:0]  index;
    logic [lfpd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/lfpd_err_stage.sv
// ----------------------------------------------------------------------------
// lfpd_err_stage
// Error, saturating integral and difference; holds the controller state.
// ----------------------------------------------------------------------------
module lfpd_err_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lfpd_pkg::t_cfg      i_regs,
    input  logic                i_valid,
    output logic                o_ready,
    input  lfpd_pkg::t_sample   i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output lfpd_pkg::t_err_item o_item
);

    logic                   [lfpd_pkg::LEVEL_W-1:0] lv, cv, rv;
    logic signed            [lfpd_pkg::ERR_W-1:0]   err;
    logic signed            [lfpd_pkg::SUM_W:0]     sum_wide;
    logic                                           all_dark, all_bright, load;
    lfpd_pkg::t_err_item                            n_item;

    logic                                           r_valid;
    lfpd_pkg::t_err_item                            r_item;
    logic signed            [lfpd_pkg::ERR_W-1:0]   r_last_error;
    logic signed            [lfpd_pkg::SUM_W-1:0]   r_error_sum;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        lv = i_item.left[lfpd_pkg::SAMPLE_W-1 -: lfpd_pkg::LEVEL_W];
        cv = i_item.center[lfpd_pkg::SAMPLE_W-1 -: lfpd_pkg::LEVEL_W];
        rv = i_item.right[lfpd_pkg::SAMPLE_W-1 -: lfpd_pkg::LEVEL_W];
        all_dark   = (cv < i_regs.dark_thr) && (rv < i_regs.dark_thr) && (lv < i_regs.dark_thr);
        all_bright = (cv > i_regs.line_thr) && (rv > i_regs.line_thr) && (lv > i_regs.line_thr);
        err = $signed({1'b0, rv}) - $signed({1'b0, lv});
        if (all_dark || all_bright) begin
            err = '0;
        end
        sum_wide = $signed({r_error_sum[lfpd_pkg::SUM_W-1], r_error_sum})
                 + $signed({{(lfpd_pkg::SUM_W+1-lfpd_pkg::ERR_W){err[lfpd_pkg::ERR_W-1]}}, err});
        n_item.err = err;
        if (sum_wide[lfpd_pkg::SUM_W] != sum_wide[lfpd_pkg::SUM_W-1]) begin
            // saturate toward the sign of the true sum
            n_item.sum = {sum_wide[lfpd_pkg::SUM_W], {(lfpd_pkg::SUM_W-1){~sum_wide[lfpd_pkg::SUM_W]}}};
        end else begin
            n_item.sum = sum_wide[lfpd_pkg::SUM_W-1:0];
        end
        n_item.diff = $signed({err[lfpd_pkg::ERR_W-1], err})
                    - $signed({r_last_error[lfpd_pkg::ERR_W-1], r_last_error});
        n_item.pivot     = cv < i_regs.line_thr;
        n_item.turn_left = lv > rv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_last_error <= '0;
            r_error_sum  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_last_error <= n_item.err;
                r_error_sum  <= n_item.sum;
            end
        end
        if (load) begin
            r_item <= n_item;
        end
    end

    a_state_tracks_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_item.err == r_last_error) && (r_item.sum == r_error_sum))
        else $error("held item disagrees with controller state");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> $stable(r_last_error) && $stable(r_error_sum))
        else $error("controller state moved during stall");

endmodule

// File: hdl/lfpd_drive_stage.sv
// ----------------------------------------------------------------------------
// lfpd_drive_stage
// PID products, truncating scale, speed saturation and pivot selection.
// ----------------------------------------------------------------------------
module lfpd_drive_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lfpd_pkg::t_cfg       i_regs,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  lfpd_pkg::t_err_item  i_item,
    lfpd_drive_if.source         o_drive
);

    localparam logic signed [lfpd_pkg::DRV_W-1:0] SPD_MAX =
        lfpd_pkg::DRV_W'((1 <<< (lfpd_pkg::OUT_W - 1)) - 1);
    localparam logic signed [lfpd_pkg::DRV_W-1:0] SPD_MIN =
        lfpd_pkg::DRV_W'(-(1 <<< (lfpd_pkg::OUT_W - 1)));
    localparam logic signed [lfpd_pkg::ACC_W-1:0] RND     =
        lfpd_pkg::ACC_W'((1 <<< lfpd_pkg::FRAC_W) - 1);

    logic signed          [lfpd_pkg::GAIN_W:0]   gp_s, gi_s, gd_s;
    lfpd_pkg::t_prod_item                        n_prod;
    logic signed          [lfpd_pkg::ACC_W-1:0]  acc, acc_adj;
    logic signed          [lfpd_pkg::PID_W-1:0]  pid;
    logic signed          [lfpd_pkg::DRV_W-1:0]  ls_wide, rs_wide;
    logic signed          [lfpd_pkg::OUT_W-1:0]  n_left, n_right;
    logic                                        prod_ready, out_adv;

    logic                                        r_prod_valid;
    lfpd_pkg::t_prod_item                        r_prod;
    logic                                        r_out_valid;
    logic signed          [lfpd_pkg::OUT_W-1:0]  r_left, r_right;
    logic                                        r_pivoting;

    assign out_adv    = !r_out_valid || o_drive.ready;
    assign prod_ready = !r_prod_valid || out_adv;
    assign o_ready    = prod_ready;

    assign o_drive.valid       = r_out_valid;
    assign o_drive.left_speed  = r_left;
    assign o_drive.right_speed = r_right;
    assign o_drive.pivoting    = r_pivoting;

    always_comb begin
        gp_s = $signed({1'b0, i_regs.gain_p});
        gi_s = $signed({1'b0, i_regs.gain_i});
        gd_s = $signed({1'b0, i_regs.gain_d});
        n_prod.prod_p = lfpd_pkg::PROD_P_W'(gp_s) * lfpd_pkg::PROD_P_W'(i_item.err);
        n_prod.prod_i = lfpd_pkg::PROD_I_W'(gi_s) * lfpd_pkg::PROD_I_W'(i_item.sum);
        n_prod.prod_d = lfpd_pkg::PROD_D_W'(gd_s) * lfpd_pkg::PROD_D_W'(i_item.diff);
        n_prod.pivot     = i_item.pivot;
        n_prod.turn_left = i_item.turn_left;
    end

    always_comb begin
        acc = lfpd_pkg::ACC_W'(r_prod.prod_p) + lfpd_pkg::ACC_W'(r_prod.prod_i)
            + lfpd_pkg::ACC_W'(r_prod.prod_d);
        // bias negatives so the shift truncates toward zero
        acc_adj = acc[lfpd_pkg::ACC_W-1] ? acc + RND : acc;
        pid     = acc_adj[lfpd_pkg::ACC_W-1:lfpd_pkg::FRAC_W];
        ls_wide = $signed({{(lfpd_pkg::DRV_W-lfpd_pkg::SPEED_W){1'b0}}, i_regs.base_left})
                + lfpd_pkg::DRV_W'(pid);
        rs_wide = $signed({{(lfpd_pkg::DRV_W-lfpd_pkg::SPEED_W){1'b0}}, i_regs.base_right})
                - lfpd_pkg::DRV_W'(pid);
        if (r_prod.pivot) begin
            if (r_prod.turn_left) begin
                n_left  = '0;
                n_right = $signed({1'b0, i_regs.pivot_speed});
            end else begin
                n_left  = $signed({1'b0, i_regs.pivot_speed});
                n_right = '0;
            end
        end else begin
            if (ls_wide > SPD_MAX) begin
                n_left = SPD_MAX[lfpd_pkg::OUT_W-1:0];
            end else if (ls_wide < SPD_MIN) begin
                n_left = SPD_MIN[lfpd_pkg::OUT_W-1:0];
            end else begin
                n_left = ls_wide[lfpd_pkg::OUT_W-1:0];
            end
            if (rs_wide > SPD_MAX) begin
                n_right = SPD_MAX[lfpd_pkg::OUT_W-1:0];
            end else if (rs_wide < SPD_MIN) begin
                n_right = SPD_MIN[lfpd_pkg::OUT_W-1:0];
            end else begin
                n_right = rs_wide[lfpd_pkg::OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (prod_ready) begin
                r_prod_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_prod_valid;
            end
        end
        if (i_valid && prod_ready) begin
            r_prod <= n_prod;
        end
        if (r_prod_valid && out_adv) begin
            r_left     <= n_left;
            r_right    <= n_right;
            r_pivoting <= r_prod.pivot;
        end
    end

    a_pivot_stops_one_wheel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_pivoting |-> (r_left == '0) || (r_right == '0))
        else $error("pivot result drives both wheels");

endmodule

// File: hdl/line_follower_pid_drive.sv
// ----------------------------------------------------------------------------
// line_follower_pid_drive
// PID steering of a differential drive from three line sensor samples.
// Registers: input sample, error/integral item, products, drive output.
// Throughput: one item per cycle unless the drive receiver stalls; the
// error/integral stage updates its state per item, so items may follow
// back to back. Reset: clears the integral, last error and all valid flags,
// and loads the register defaults. Register writes are taken every cycle.
// ----------------------------------------------------------------------------
module line_follower_pid_drive (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lfpd_sample_if.sink  i_sample,
    lfpd_drive_if.source o_drive,
    lfpd_cfg_if.sink     i_cfg
);

    lfpd_pkg::t_cfg      r_regs;
    logic                r_in_valid;
    lfpd_pkg::t_sample   r_in;
    logic                err_ready, err_valid, drv_ready;
    lfpd_pkg::t_err_item err_item;

    assign i_cfg.ready    = 1'b1;
    assign i_sample.ready = !r_in_valid || err_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.gain_p      <= lfpd_pkg::RST_GAIN_P;
            r_regs.gain_i      <= lfpd_pkg::RST_GAIN_I;
            r_regs.gain_d      <= lfpd_pkg::RST_GAIN_D;
            r_regs.base_left   <= lfpd_pkg::RST_SPEED;
            r_regs.base_right  <= lfpd_pkg::RST_SPEED;
            r_regs.pivot_speed <= lfpd_pkg::RST_SPEED;
            r_regs.line_thr    <= lfpd_pkg::RST_LINE;
            r_regs.dark_thr    <= lfpd_pkg::RST_DARK;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                lfpd_pkg::REG_GAIN_P:     r_regs.gain_p      <= i_cfg.data[lfpd_pkg::GAIN_W-1:0];
                lfpd_pkg::REG_GAIN_I:     r_regs.gain_i      <= i_cfg.data[lfpd_pkg::GAIN_W-1:0];
                lfpd_pkg::REG_GAIN_D:     r_regs.gain_d      <= i_cfg.data[lfpd_pkg::GAIN_W-1:0];
                lfpd_pkg::REG_BASE_LEFT:  r_regs.base_left   <= i_cfg.data[lfpd_pkg::SPEED_W-1:0];
                lfpd_pkg::REG_BASE_RIGHT: r_regs.base_right  <= i_cfg.data[lfpd_pkg::SPEED_W-1:0];
                lfpd_pkg::REG_PIVOT:      r_regs.pivot_speed <= i_cfg.data[lfpd_pkg::SPEED_W-1:0];
                lfpd_pkg::REG_LINE_THR:   r_regs.line_thr    <= i_cfg.data[lfpd_pkg::LEVEL_W-1:0];
                lfpd_pkg::REG_DARK_THR:   r_regs.dark_thr    <= i_cfg.data[lfpd_pkg::LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
        if (i_sample.valid && i_sample.ready) begin
            r_in.left   <= i_sample.left_sample;
            r_in.center <= i_sample.center_sample;
            r_in.right  <= i_sample.right_sample;
        end
    end

    lfpd_err_stage u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_regs  (r_regs),
        .i_valid (r_in_valid),
        .o_ready (err_ready),
        .i_item  (r_in),
        .o_valid (err_valid),
        .i_ready (drv_ready),
        .o_item  (err_item)
    );

    lfpd_drive_stage u_drive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_regs  (r_regs),
        .i_valid (err_valid),
        .o_ready (drv_ready),
        .i_item  (err_item),
        .o_drive (o_drive)
    );

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for line_follower_pid_drive. Sample items come from a
// queue through a clocked driver. A shadow copy of the registers and the PID
// state predicts each drive item, and a clocked monitor compares the drive
// items with those predictions in order. The run starts with directed edge
// cases under reset and extreme settings. Next come tracking, threshold and
// noise items, a long receiver hold-off, and an integral windup in both
// directions. Random settings close the run, with several patterns of sender
// gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int          LATENCY     = 4;
    localparam int          HOLD_CYCLES = 200;
    localparam int          REPORT_MAX  = 10;
    localparam int unsigned CYCLE_LIMIT = 200000;

    localparam logic [lfpd_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED = 8'd8;
    localparam logic [lfpd_pkg::CFG_IDX_W-1:0] REG_LAST_UNUSED  = 8'hFF;

    typedef enum int {
        PICK_ANY,
        PICK_EDGE,
        PICK_TRACK,
        PICK_WIND_UP,
        PICK_WIND_DOWN
    } t_pick;

    typedef struct packed {
        logic signed [lfpd_pkg::OUT_W-1:0] left_speed;
        logic signed [lfpd_pkg::OUT_W-1:0] right_speed;
        logic                              pivoting;
    } t_wheel_cmd;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lfpd_sample_if smp ();
    lfpd_drive_if  drv ();
    lfpd_cfg_if    cfg_bus ();

    lfpd_pkg::t_sample sample_backlog[$];
    t_wheel_cmd        wheel_cmds_due[$];
    lfpd_pkg::t_cfg    shadow_cfg;
    int                integral_est;
    int                prev_err_est;
    int                idle_pct;
    int                stall_pct;
    int                track_pos;
    int                mismatches;
    int unsigned       cycle_count = 0;
    int unsigned       hold_left;
    bit                hold_req  = 1'b0;
    bit                hold_seen = 1'b0;
    lfpd_pkg::t_sample next_smp;
    t_wheel_cmd        want_cmd;

    line_follower_pid_drive uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(smp),
        .o_drive (drv),
        .i_cfg   (cfg_bus)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic predict_wheels(input lfpd_pkg::t_sample s);
        int         lvl_l;
        int         lvl_c;
        int         lvl_r;
        int         err;
        int         slope;
        int         thr_line;
        int         thr_dark;
        longint     kp;
        longint     ki;
        longint     kd;
        longint     sum_next;
        longint     acc;
        longint     corr;
        longint     spd_l;
        longint     spd_r;
        bit         all_dark;
        bit         all_bright;
        t_wheel_cmd cmd;
        lvl_l    = int'(s.left[lfpd_pkg::SAMPLE_W-1:2]);
        lvl_c    = int'(s.center[lfpd_pkg::SAMPLE_W-1:2]);
        lvl_r    = int'(s.right[lfpd_pkg::SAMPLE_W-1:2]);
        thr_line = int'(shadow_cfg.line_thr);
        thr_dark = int'(shadow_cfg.dark_thr);
        kp       = longint'(shadow_cfg.gain_p);
        ki       = longint'(shadow_cfg.gain_i);
        kd       = longint'(shadow_cfg.gain_d);
        err        = lvl_r - lvl_l;
        all_dark   = (lvl_l < thr_dark) && (lvl_c < thr_dark) && (lvl_r < thr_dark);
        all_bright = (lvl_l > thr_line) && (lvl_c > thr_line) && (lvl_r > thr_line);
        if (all_dark || all_bright) begin
            err = 0;
        end
        sum_next = clamp(longint'(integral_est) + err, -32768, 32767);
        slope    = err - prev_err_est;
        acc      = kp * err + ki * sum_next + kd * slope;
        corr     = acc / 1024;
        integral_est = int'(sum_next);
        prev_err_est = err;
        cmd.pivoting = lvl_c < thr_line;
        if (cmd.pivoting) begin
            if (lvl_l > lvl_r) begin
                cmd.left_speed  = '0;
                cmd.right_speed = lfpd_pkg::OUT_W'(shadow_cfg.pivot_speed);
            end else begin
                cmd.left_speed  = lfpd_pkg::OUT_W'(shadow_cfg.pivot_speed);
                cmd.right_speed = '0;
            end
        end else begin
            spd_l = clamp(longint'(shadow_cfg.base_left) + corr, -128, 127);
            spd_r = clamp(longint'(shadow_cfg.base_right) - corr, -128, 127);
            cmd.left_speed  = spd_l[lfpd_pkg::OUT_W-1:0];
            cmd.right_speed = spd_r[lfpd_pkg::OUT_W-1:0];
        end
        wheel_cmds_due.push_back(cmd);
    endtask

    function automatic logic [lfpd_pkg::SAMPLE_W-1:0] raw_of(input int v);
        return lfpd_pkg::SAMPLE_W'(clamp(v, 0, 255));
    endfunction

    function automatic logic [lfpd_pkg::SAMPLE_W-1:0] edge_raw();
        int lvl;
        case ($urandom_range(4))
            0: lvl = 0;
            1: lvl = 63;
            2: lvl = int'(shadow_cfg.line_thr) - 1 + int'($urandom_range(2));
            3: lvl = int'(shadow_cfg.dark_thr) - 1 + int'($urandom_range(2));
            default: lvl = $urandom_range(63);
        endcase
        return raw_of(int'(clamp(lvl, 0, 63)) * 4 + int'($urandom_range(3)));
    endfunction

    function automatic lfpd_pkg::t_sample next_sample(input t_pick how);
        lfpd_pkg::t_sample s;
        int                span;
        case (how)
            PICK_EDGE: begin
                s.left   = edge_raw();
                s.center = edge_raw();
                s.right  = edge_raw();
            end
            PICK_TRACK: begin
                track_pos = int'(clamp(track_pos + int'($urandom_range(12)) - 6, -60, 60));
                span      = (track_pos < 0) ? -track_pos : track_pos;
                s.left    = raw_of(128 - 2 * track_pos + int'($urandom_range(16)) - 8);
                s.right   = raw_of(128 + 2 * track_pos + int'($urandom_range(16)) - 8);
                s.center  = raw_of(250 - 4 * span + int'($urandom_range(16)) - 8);
            end
            PICK_WIND_UP: begin
                s.left   = lfpd_pkg::SAMPLE_W'($urandom_range(3));
                s.center = lfpd_pkg::SAMPLE_W'($urandom);
                s.right  = lfpd_pkg::SAMPLE_W'($urandom_range(255, 252));
            end
            PICK_WIND_DOWN: begin
                s.left   = lfpd_pkg::SAMPLE_W'($urandom_range(255, 252));
                s.center = lfpd_pkg::SAMPLE_W'($urandom);
                s.right  = lfpd_pkg::SAMPLE_W'($urandom_range(3));
            end
            default: begin
                s.left   = lfpd_pkg::SAMPLE_W'($urandom);
                s.center = lfpd_pkg::SAMPLE_W'($urandom);
                s.right  = lfpd_pkg::SAMPLE_W'($urandom);
            end
        endcase
        return s;
    endfunction

    function automatic logic [lfpd_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return lfpd_pkg::GAIN_W'($urandom_range(4096));
            default: return lfpd_pkg::GAIN_W'($urandom);
        endcase
    endfunction

    task automatic queue_raw(input logic [lfpd_pkg::SAMPLE_W-1:0] l,
                             input logic [lfpd_pkg::SAMPLE_W-1:0] c,
                             input logic [lfpd_pkg::SAMPLE_W-1:0] r);
        sample_backlog.push_back('{left: l, center: c, right: r});
    endtask

    task automatic queue_mix(input int count);
        int r;
        repeat (count) begin
            r = $urandom_range(99);
            sample_backlog.push_back(next_sample(r < 50 ? PICK_TRACK :
                                                 r < 75 ? PICK_EDGE : PICK_ANY));
        end
    endtask

    task automatic wait_idle();
        while (sample_backlog.size() != 0 || smp.valid || wheel_cmds_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lfpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lfpd_pkg::CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            lfpd_pkg::REG_GAIN_P:     shadow_cfg.gain_p      = val;
            lfpd_pkg::REG_GAIN_I:     shadow_cfg.gain_i      = val;
            lfpd_pkg::REG_GAIN_D:     shadow_cfg.gain_d      = val;
            lfpd_pkg::REG_BASE_LEFT:  shadow_cfg.base_left   = val[lfpd_pkg::SPEED_W-1:0];
            lfpd_pkg::REG_BASE_RIGHT: shadow_cfg.base_right  = val[lfpd_pkg::SPEED_W-1:0];
            lfpd_pkg::REG_PIVOT:      shadow_cfg.pivot_speed = val[lfpd_pkg::SPEED_W-1:0];
            lfpd_pkg::REG_LINE_THR:   shadow_cfg.line_thr    = val[lfpd_pkg::LEVEL_W-1:0];
            lfpd_pkg::REG_DARK_THR:   shadow_cfg.dark_thr    = val[lfpd_pkg::LEVEL_W-1:0];
            default: ;
        endcase
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_random_config();
        logic [lfpd_pkg::CFG_IDX_W-1:0] spare;
        spare = REG_FIRST_UNUSED
              + lfpd_pkg::CFG_IDX_W'($urandom_range(REG_LAST_UNUSED - REG_FIRST_UNUSED));
        write_reg(lfpd_pkg::REG_GAIN_P, pick_gain());
        write_reg(lfpd_pkg::REG_GAIN_I, pick_gain());
        write_reg(lfpd_pkg::REG_GAIN_D, pick_gain());
        write_reg(lfpd_pkg::REG_BASE_LEFT, lfpd_pkg::CFG_DATA_W'($urandom));
        write_reg(lfpd_pkg::REG_BASE_RIGHT, lfpd_pkg::CFG_DATA_W'($urandom));
        write_reg(lfpd_pkg::REG_PIVOT, lfpd_pkg::CFG_DATA_W'($urandom));
        write_reg(lfpd_pkg::REG_LINE_THR, lfpd_pkg::CFG_DATA_W'($urandom));
        write_reg(lfpd_pkg::REG_DARK_THR, lfpd_pkg::CFG_DATA_W'($urandom));
        write_reg(spare, lfpd_pkg::CFG_DATA_W'($urandom));
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
        end else begin
            if (smp.valid && smp.ready) begin
                predict_wheels('{left: smp.left_sample, center: smp.center_sample,
                                 right: smp.right_sample});
            end
            if (!smp.valid || smp.ready) begin
                if (sample_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    next_smp = sample_backlog.pop_front();
                    smp.valid         <= 1'b1;
                    smp.left_sample   <= next_smp.left;
                    smp.center_sample <= next_smp.center;
                    smp.right_sample  <= next_smp.right;
                end else begin
                    smp.valid <= 1'b0;
                end
            end
        end
    end

    // drive monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv.ready <= 1'b0;
        end else begin
            if (drv.valid && drv.ready) begin
                if (wheel_cmds_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected drive item: left %0d right %0d pivot %0b",
                                 drv.left_speed, drv.right_speed, drv.pivoting);
                end else begin
                    want_cmd = wheel_cmds_due.pop_front();
                    if (want_cmd.left_speed !== drv.left_speed
                            || want_cmd.right_speed !== drv.right_speed
                            || want_cmd.pivoting !== drv.pivoting) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("drive mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                                     want_cmd.left_speed, want_cmd.right_speed,
                                     want_cmd.pivoting, drv.left_speed, drv.right_speed,
                                     drv.pivoting);
                    end
                end
            end
            drv.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_req;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        smp.valid         = 1'b0;
        smp.left_sample   = '0;
        smp.center_sample = '0;
        smp.right_sample  = '0;
        drv.ready         = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = '0;
        cfg_bus.data      = '0;
        shadow_cfg = '{gain_p: lfpd_pkg::RST_GAIN_P, gain_i: lfpd_pkg::RST_GAIN_I,
                       gain_d: lfpd_pkg::RST_GAIN_D, base_left: lfpd_pkg::RST_SPEED,
                       base_right: lfpd_pkg::RST_SPEED, pivot_speed: lfpd_pkg::RST_SPEED,
                       line_thr: lfpd_pkg::RST_LINE, dark_thr: lfpd_pkg::RST_DARK};
        integral_est = 0;
        prev_err_est = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        track_pos    = 0;
        mismatches   = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_raw(8'd0, 8'd0, 8'd0);
        queue_raw(8'd255, 8'd255, 8'd255);
        queue_raw(8'd255, 8'd255, 8'd0);
        queue_raw(8'd0, 8'd255, 8'd255);
        queue_raw(8'd3, 8'd127, 8'd252);
        queue_raw(8'd200, 8'd40, 8'd10);
        queue_raw(8'd10, 8'd40, 8'd200);
        queue_raw(8'd128, 8'd119, 8'd128);
        queue_raw(8'd128, 8'd120, 8'd128);
        queue_raw(8'd19, 8'd19, 8'd19);
        queue_raw(8'd20, 8'd20, 8'd20);
        wait_idle();

        write_reg(lfpd_pkg::REG_GAIN_P, 16'hFFFF);
        write_reg(lfpd_pkg::REG_GAIN_I, 16'hFFFF);
        write_reg(lfpd_pkg::REG_GAIN_D, 16'hFFFF);
        write_reg(lfpd_pkg::REG_BASE_LEFT, 16'hFFFF);
        write_reg(lfpd_pkg::REG_BASE_RIGHT, 16'hFF80);
        write_reg(lfpd_pkg::REG_PIVOT, 16'hFFFF);
        write_reg(lfpd_pkg::REG_LINE_THR, 16'hFFFF);
        write_reg(lfpd_pkg::REG_DARK_THR, 16'hFFC0);
        write_reg(REG_FIRST_UNUSED, 16'h0000);
        write_reg(REG_LAST_UNUSED, 16'h0000);
        queue_raw(8'd0, 8'd255, 8'd255);
        queue_raw(8'd255, 8'd255, 8'd0);
        queue_raw(8'd255, 8'd255, 8'd0);
        queue_raw(8'd0, 8'd0, 8'd0);
        wait_idle();

        write_reg(lfpd_pkg::REG_GAIN_P, 16'h0000);
        write_reg(lfpd_pkg::REG_GAIN_I, 16'h0000);
        write_reg(lfpd_pkg::REG_GAIN_D, 16'h0000);
        write_reg(lfpd_pkg::REG_BASE_LEFT, 16'h0000);
        write_reg(lfpd_pkg::REG_LINE_THR, 16'h0000);
        write_reg(lfpd_pkg::REG_DARK_THR, 16'hFFFF);
        queue_raw(8'd0, 8'd0, 8'd0);
        queue_raw(8'd255, 8'd255, 8'd255);
        queue_raw(8'd0, 8'd255, 8'd252);
        wait_idle();

        write_reg(lfpd_pkg::REG_GAIN_P, lfpd_pkg::RST_GAIN_P);
        write_reg(lfpd_pkg::REG_GAIN_I, lfpd_pkg::RST_GAIN_I);
        write_reg(lfpd_pkg::REG_GAIN_D, lfpd_pkg::RST_GAIN_D);
        write_reg(lfpd_pkg::REG_BASE_LEFT, lfpd_pkg::CFG_DATA_W'(lfpd_pkg::RST_SPEED));
        write_reg(lfpd_pkg::REG_BASE_RIGHT, lfpd_pkg::CFG_DATA_W'(lfpd_pkg::RST_SPEED));
        write_reg(lfpd_pkg::REG_PIVOT, lfpd_pkg::CFG_DATA_W'(lfpd_pkg::RST_SPEED));
        write_reg(lfpd_pkg::REG_LINE_THR, lfpd_pkg::CFG_DATA_W'(lfpd_pkg::RST_LINE));
        write_reg(lfpd_pkg::REG_DARK_THR, lfpd_pkg::CFG_DATA_W'(lfpd_pkg::RST_DARK));
        queue_mix(30);
        wait_idle();
        hold_req <= ~hold_req;
        queue_mix(60);
        wait_idle();

        // push the integral up, then down
        write_reg(lfpd_pkg::REG_GAIN_P, 16'd0);
        write_reg(lfpd_pkg::REG_GAIN_I, 16'd1);
        write_reg(lfpd_pkg::REG_GAIN_D, 16'd0);
        repeat (80) sample_backlog.push_back(next_sample(PICK_WIND_UP));
        repeat (80) sample_backlog.push_back(next_sample(PICK_WIND_DOWN));
        wait_idle();

        write_random_config();
        idle_pct = 60;
        queue_mix(50);
        wait_idle();
        queue_mix(50);
        wait_idle();

        write_random_config();
        idle_pct  = 0;
        stall_pct = 60;
        queue_mix(90);
        wait_idle();

        write_random_config();
        idle_pct  = 25;
        stall_pct = 25;
        queue_mix(90);
        wait_idle();

        repeat (LATENCY * 4) @(posedge i_clk);
        if (mismatches == 0 && wheel_cmds_due.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// File: line_follower_pid_drive.f
hdl/lfpd_pkg.sv
hdl/lfpd_intf.sv
hdl/lfpd_err_stage.sv
hdl/lfpd_drive_stage.sv
hdl/line_follower_pid_drive.sv
bench/tb.sv
